>>> design/mono_framebuffer_plot_engine_macros.svh
// assertion macros used by the plot engine checker
`ifndef MONO_FRAMEBUFFER_PLOT_ENGINE_MACROS_SVH
`define MONO_FRAMEBUFFER_PLOT_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MFPE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define MFPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/mfpe_pkg.sv
// shared codes and field widths of the frame buffer plot engine
package mfpe_pkg;

	localparam int MODE_W     = 3;
	localparam int COORD_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	// command codes
	localparam logic [MODE_W-1:0] CMD_PLOT  = 3'd0;
	localparam logic [MODE_W-1:0] CMD_READ  = 3'd1;
	localparam logic [MODE_W-1:0] CMD_FILL  = 3'd2;
	localparam logic [MODE_W-1:0] CMD_ERASE = 3'd3;
	localparam logic [MODE_W-1:0] CMD_CLEAR = 3'd4;

	// draw modes
	localparam logic [1:0] DRAW_NORMAL = 2'd0;
	localparam logic [1:0] DRAW_XOR    = 2'd1;
	localparam logic [1:0] DRAW_ANDINV = 2'd2;

	// rotations
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOUR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOUR = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;

endpackage

>>> design/mfpe_if.sv
// command and result channel interfaces of the plot engine
interface mfpe_cmd_if import mfpe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	coord_t            x_first;
	coord_t            y_first;
	coord_t            x_last;
	coord_t            y_last;

	modport source (output valid, mode, x_first, y_first, x_last, y_last, input ready);
	modport sink (input valid, mode, x_first, y_first, x_last, y_last, output ready);
endinterface

interface mfpe_res_if;
	logic valid;
	logic ready;
	logic pixel_value;
	logic was_read;

	modport source (output valid, pixel_value, was_read, input ready);
	modport sink (input valid, pixel_value, was_read, output ready);
endinterface

>>> design/mono_framebuffer_plot_engine.sv
// monochrome frame buffer plot engine: rotate, clip and plot into a column-major byte store
// One command word is taken at a time and answered with exactly one result word. Each
// byte of the store holds eight vertical pixels of one column, byte x*ROWS + y/8. The
// store is a single-port memory; every change that a plot, fill or erase makes is a
// read-modify-write of one byte, a read state and then a write state, so that port sets
// the pace. A plot or read passes from its acceptance through the clip, bounds, column
// base, read, write and result states back to idle. A fill or erase repeats read and
// write for every byte that the on-screen part of the rectangle touches (columns times
// byte rows); a rectangle or pixel that misses the screen goes from bounds to result.
// Clear writes zero to every byte, one a cycle, then gives its result. After reset the
// same clearing pass runs before the first command is accepted; configuration writes are
// taken throughout. A finished result waits in an output register, so the next command
// can be worked on while the previous result is still not taken. The user must write
// rotation, draw mode and colours through the cfg port only while the engine is idle;
// the engine itself does not enforce this.
module mono_framebuffer_plot_engine
	import mfpe_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 84,
	parameter int SCREEN_HEIGHT = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mfpe_cmd_if.sink              cmd,
	mfpe_res_if.source            res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// store geometry
	localparam int ROWS  = (SCREEN_HEIGHT + 7) / 8;
	localparam int DEPTH = SCREEN_WIDTH * ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int PXW   = $clog2(SCREEN_WIDTH);
	localparam int PYW   = ($clog2(SCREEN_HEIGHT) < 4) ? 4 : $clog2(SCREEN_HEIGHT);
	localparam int RW    = PYW - 3;

	localparam coord_t W_M1 = COORD_W'(SCREEN_WIDTH - 1);
	localparam coord_t H_M1 = COORD_W'(SCREEN_HEIGHT - 1);
	localparam logic [AW-1:0] ROWS_A = AW'(ROWS);
	localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

	// sequencer states
	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CLIP  = 4'd2;
	localparam logic [3:0] S_BOUND = 4'd3;
	localparam logic [3:0] S_BASE  = 4'd4;
	localparam logic [3:0] S_RD    = 4'd5;
	localparam logic [3:0] S_WR    = 4'd6;
	localparam logic [3:0] S_SWEEP = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0] state_q;

	// configuration registers
	logic [1:0] rot_q;
	logic [1:0] dmode_q;
	logic       fcol_q;
	logic       bcol_q;

	// command being worked on
	logic [MODE_W-1:0] mode_q;
	coord_t            xa_q;
	coord_t            ya_q;
	coord_t            xb_q;
	coord_t            yb_q;
	logic              colour_q;
	logic              res_pix_q;
	logic              res_rd_q;

	// physical rectangle and walk position
	logic [PXW-1:0] pxa_q;
	logic [PXW-1:0] pxb_q;
	logic [PYW-1:0] pya_q;
	logic [PYW-1:0] pyb_q;
	logic [PXW-1:0] px_q;
	logic [RW-1:0]  row_q;
	logic [AW-1:0]  col_base_q;
	logic [AW-1:0]  cnt_q;

	// frame store
	logic [7:0]    frame_mem [DEPTH];
	logic [7:0]    rd_data_q;
	logic [AW-1:0] mem_addr;
	logic          mem_we;
	logic          mem_re;
	logic [7:0]    mem_wd;
	logic          sweeping;

	// output register
	logic out_valid_q;
	logic out_pix_q;
	logic out_rd_q;

	// clip and rotation datapath
	coord_t   lw_m1;
	coord_t   lh_m1;
	coord_t   rx_lo;
	coord_t   rx_hi;
	coord_t   ry_lo;
	coord_t   ry_hi;
	logic     rect_empty;
	logic [2:0] bit_lo;
	logic [2:0] bit_hi;
	logic [7:0] mask;
	logic [7:0] new_byte;
	logic       row_end;
	logic       col_end;

	assign cmd.ready       = (state_q == S_IDLE);
	assign res.valid       = out_valid_q;
	assign res.pixel_value = out_pix_q;
	assign res.was_read    = out_rd_q;

	// logical screen swaps its sides for quarter turns
	always_comb begin
		if (rot_q == ROT_90 || rot_q == ROT_270) begin
			lw_m1 = H_M1;
			lh_m1 = W_M1;
		end else begin
			lw_m1 = W_M1;
			lh_m1 = H_M1;
		end
	end

	assign rect_empty = (xa_q > xb_q) || (ya_q > yb_q);

	// map the clipped logical rectangle onto physical columns and rows
	always_comb begin
		unique case (rot_q)
			ROT_90: begin
				rx_lo = W_M1 - yb_q;
				rx_hi = W_M1 - ya_q;
				ry_lo = xa_q;
				ry_hi = xb_q;
			end
			ROT_180: begin
				rx_lo = W_M1 - xb_q;
				rx_hi = W_M1 - xa_q;
				ry_lo = H_M1 - yb_q;
				ry_hi = H_M1 - ya_q;
			end
			ROT_270: begin
				rx_lo = ya_q;
				rx_hi = yb_q;
				ry_lo = H_M1 - xb_q;
				ry_hi = H_M1 - xa_q;
			end
			default: begin
				rx_lo = xa_q;
				rx_hi = xb_q;
				ry_lo = ya_q;
				ry_hi = yb_q;
			end
		endcase
	end

	// bits of the current byte that fall inside the rectangle
	assign bit_lo = (row_q == pya_q[PYW-1:3]) ? pya_q[2:0] : 3'd0;
	assign bit_hi = (row_q == pyb_q[PYW-1:3]) ? pyb_q[2:0] : 3'd7;
	assign mask   = (8'hFF << bit_lo) & (8'hFF >> (3'd7 - bit_hi));

	always_comb begin
		case (dmode_q)
			DRAW_NORMAL: new_byte = colour_q ? (rd_data_q | mask) : (rd_data_q & ~mask);
			DRAW_XOR:    new_byte = colour_q ? (rd_data_q ^ mask) : rd_data_q;
			DRAW_ANDINV: new_byte = rd_data_q & ~mask;
			default:     new_byte = rd_data_q;
		endcase
	end

	assign row_end = (row_q == pyb_q[PYW-1:3]);
	assign col_end = (px_q == pxb_q);

	// memory port control
	assign sweeping = (state_q == S_INIT) || (state_q == S_SWEEP);
	assign mem_addr = sweeping ? cnt_q : (col_base_q + AW'(row_q));
	assign mem_re   = (state_q == S_RD);
	assign mem_we   = sweeping || ((state_q == S_WR) && (mode_q != CMD_READ));
	assign mem_wd   = sweeping ? 8'h00 : new_byte;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[mem_addr] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= frame_mem[mem_addr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q   <= ROT_0;
			dmode_q <= DRAW_NORMAL;
			fcol_q  <= 1'b1;
			bcol_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ROTATION:    rot_q   <= cfg_data[1:0];
				REG_DRAW_MODE:   dmode_q <= cfg_data[1:0];
				REG_FORE_COLOUR: fcol_q  <= cfg_data[0];
				REG_BACK_COLOUR: bcol_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q   <= '0;
		end else begin
			unique case (state_q) inside
				S_INIT, S_SWEEP: begin
					if (cnt_q == LAST_A) begin
						state_q <= (state_q == S_INIT) ? S_IDLE : S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (cmd.valid) begin
						case (cmd.mode) inside
							CMD_PLOT, CMD_READ, CMD_FILL, CMD_ERASE: state_q <= S_CLIP;
							CMD_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_SWEEP;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CLIP:  state_q <= S_BOUND;
				S_BOUND: state_q <= rect_empty ? S_DONE : S_BASE;
				S_BASE:  state_q <= S_RD;
				S_RD:    state_q <= S_WR;
				S_WR: begin
					if (mode_q == CMD_READ || (row_end && col_end)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || res.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	// command payload, clipping and walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q    <= cmd.mode;
				xa_q      <= cmd.x_first;
				ya_q      <= cmd.y_first;
				res_pix_q <= 1'b0;
				res_rd_q  <= (cmd.mode == CMD_READ);
				colour_q  <= (cmd.mode == CMD_ERASE) ? bcol_q : fcol_q;
				// a single pixel is a one-by-one rectangle
				if (cmd.mode == CMD_FILL || cmd.mode == CMD_ERASE) begin
					xb_q <= cmd.x_last;
					yb_q <= cmd.y_last;
				end else begin
					xb_q <= cmd.x_first;
					yb_q <= cmd.y_first;
				end
			end
			S_CLIP: begin
				if (xa_q < 0) xa_q <= '0;
				if (ya_q < 0) ya_q <= '0;
				if (xb_q > lw_m1) xb_q <= lw_m1;
				if (yb_q > lh_m1) yb_q <= lh_m1;
			end
			S_BOUND: begin
				pxa_q <= rx_lo[PXW-1:0];
				pxb_q <= rx_hi[PXW-1:0];
				pya_q <= ry_lo[PYW-1:0];
				pyb_q <= ry_hi[PYW-1:0];
			end
			S_BASE: begin
				col_base_q <= AW'(AW'(pxa_q) * ROWS_A);
				px_q       <= pxa_q;
				row_q      <= pya_q[PYW-1:3];
			end
			S_WR: begin
				if (mode_q == CMD_READ) begin
					res_pix_q <= rd_data_q[pya_q[2:0]];
				end else if (row_end) begin
					px_q       <= px_q + 1'b1;
					col_base_q <= col_base_q + ROWS_A;
					row_q      <= pya_q[PYW-1:3];
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || res.ready)) begin
			out_pix_q <= res_pix_q;
			out_rd_q  <= res_rd_q;
		end
	end

endmodule

>>> design/mfpe_checker.sv
// port-level checks of the plot engine and their binding
`include "mono_framebuffer_plot_engine_macros.svh"

module mfpe_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic pixel_value,
	input logic was_read
);

	// a stalled result word holds
	`MFPE_ASSERT_NEXT(a_res_hold, out_valid && !out_ready, out_valid && $stable(pixel_value) && $stable(was_read), "result word changed while stalled")

	// only one command at a time is taken
	`MFPE_ASSERT_NEXT(a_one_cmd, in_valid && in_ready, !in_ready, "command taken while busy")

	// a set pixel only ever answers a read
	`MFPE_ASSERT_NOW(a_pix_read, out_valid && pixel_value, was_read, "pixel value without read")

endmodule

bind mono_framebuffer_plot_engine mfpe_checker u_mfpe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (cmd.valid),
	.in_ready    (cmd.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.pixel_value (res.pixel_value),
	.was_read    (res.was_read)
);

>>> verif/testbench.sv
// testbench for the frame buffer plot engine: directed table, random phases, shadow frame checking
module testbench;
	import mfpe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// screen geometry, kept equal to the engine's defaults
	localparam int WIDTH       = 84;
	localparam int HEIGHT      = 48;
	localparam int BYTE_ROWS   = (HEIGHT + 7) / 8;
	localparam int STORE_BYTES = WIDTH * BYTE_ROWS;

	// commands above clear are spare and must answer with an empty word
	localparam logic [MODE_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] CMD_SPARE_LAST  = 3'd7;
	// draw mode with no effect on any pixel
	localparam logic [1:0]        DRAW_SPARE      = 2'd3;

	// roughly 1150 counted commands; spare commands are not counted
	localparam int ITEM_TARGET = 1150;
	// worst case: every command a full-screen rectangle, plus the clearing pass after
	// reset and random stalls, taken about three times over
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	// settling time after the last answer
	localparam int TAIL_CYCLES = 24;

	typedef struct packed {
		logic pixel_value;
		logic was_read;
	} answer_t;

	typedef enum bit {ROW_CMD, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		logic [MODE_W-1:0]       mode;
		int                      xf;
		int                      yf;
		int                      xl;
		int                      yl;
		logic [CFG_IDX_W-1:0]    reg_idx;
		logic [CFG_DATA_W-1:0]   reg_val;
		bit                      typed;
		answer_t                 typed_ans;
	} script_row_t;

	localparam answer_t READ_ZERO = '{pixel_value: 1'b0, was_read: 1'b1};
	localparam answer_t NO_ANSWER = '{pixel_value: 1'b0, was_read: 1'b0};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	mfpe_cmd_if cmd ();
	mfpe_res_if res ();

	mono_framebuffer_plot_engine #(
		.SCREEN_WIDTH (WIDTH),
		.SCREEN_HEIGHT(HEIGHT)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.res     (res),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	// shadow copy of the frame store and of the four registers
	logic [7:0]  shadow_frame [STORE_BYTES];
	logic [1:0]  cur_rotation;
	logic [1:0]  cur_draw;
	logic        cur_fore;
	logic        cur_back;

	// answers still owed by the engine, oldest first
	answer_t     awaited_answers [$];

	int          mismatches;
	int          commands_sent;
	int unsigned cycle_count;
	// while set, neither side idles
	bit          calm;

	script_row_t directed_rows [$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------- shadow model

	function automatic void wipe_frame();
		foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
	endfunction

	// logical to physical coordinates; returns 1 when the point lands on screen
	function automatic bit to_physical(input int x, input int y, output int px, output int py);
		int rx;
		int ry;
		rx = x;
		ry = y;
		case (cur_rotation)
			ROT_90: begin
				rx = (WIDTH - 1) - y;
				ry = x;
			end
			ROT_180: begin
				rx = (WIDTH - 1) - x;
				ry = (HEIGHT - 1) - y;
			end
			ROT_270: begin
				rx = y;
				ry = (HEIGHT - 1) - x;
			end
			default: ;
		endcase
		px = rx;
		py = ry;
		return rx >= 0 && rx < WIDTH && ry >= 0 && ry < HEIGHT;
	endfunction

	function automatic void paint_pixel(int x, int y, logic colour);
		int         px;
		int         py;
		int         idx;
		logic [7:0] mask;
		if (!to_physical(x, y, px, py)) return;
		idx  = px * BYTE_ROWS + py / 8;
		mask = 8'h01 << (py % 8);
		case (cur_draw)
			DRAW_NORMAL: begin
				if (colour) shadow_frame[idx] = shadow_frame[idx] | mask;
				else shadow_frame[idx] = shadow_frame[idx] & ~mask;
			end
			DRAW_XOR: begin
				if (colour) shadow_frame[idx] = shadow_frame[idx] ^ mask;
			end
			DRAW_ANDINV: shadow_frame[idx] = shadow_frame[idx] & ~mask;
			default: ;
		endcase
	endfunction

	function automatic logic sample_pixel(int x, int y);
		int px;
		int py;
		if (!to_physical(x, y, px, py)) return 1'b0;
		return shadow_frame[px * BYTE_ROWS + py / 8][py % 8];
	endfunction

	// clip to the logical screen (axes swap on quarter turns), then walk what is left
	function automatic void paint_rect(int x1, int y1, int x2, int y2, logic colour);
		int lw;
		int lh;
		lw = WIDTH;
		lh = HEIGHT;
		if (cur_rotation == ROT_90 || cur_rotation == ROT_270) begin
			lw = HEIGHT;
			lh = WIDTH;
		end
		if (x1 < 0) x1 = 0;
		if (y1 < 0) y1 = 0;
		if (x2 > lw - 1) x2 = lw - 1;
		if (y2 > lh - 1) y2 = lh - 1;
		for (int x = x1; x <= x2; x++)
			for (int y = y1; y <= y2; y++)
				paint_pixel(x, y, colour);
	endfunction

	// applies one accepted command to the shadow frame and gives the answer it owes
	function automatic answer_t predict_answer(logic [MODE_W-1:0] m, coord_t xf, coord_t yf,
			coord_t xl, coord_t yl);
		answer_t ans;
		ans = NO_ANSWER;
		case (m)
			CMD_PLOT:  paint_pixel(int'(xf), int'(yf), cur_fore);
			CMD_READ: begin
				ans.pixel_value = sample_pixel(int'(xf), int'(yf));
				ans.was_read    = 1'b1;
			end
			CMD_FILL:  paint_rect(int'(xf), int'(yf), int'(xl), int'(yl), cur_fore);
			CMD_ERASE: paint_rect(int'(xf), int'(yf), int'(xl), int'(yl), cur_back);
			CMD_CLEAR: wipe_frame();
			default: ;
		endcase
		return ans;
	endfunction

	// ---------------------------------------------------------------- directed table

	function automatic script_row_t cmd_row(logic [MODE_W-1:0] m, int xf = 0, int yf = 0,
			int xl = 0, int yl = 0);
		script_row_t r;
		r           = '{kind: ROW_CMD, default: '0};
		r.kind      = ROW_CMD;
		r.mode      = m;
		r.xf        = xf;
		r.yf        = yf;
		r.xl        = xl;
		r.yl        = yl;
		r.typed     = 1'b0;
		r.typed_ans = NO_ANSWER;
		return r;
	endfunction

	// a command whose answer is obvious and typed in here
	function automatic script_row_t known_row(logic [MODE_W-1:0] m, int xf, int yf, answer_t ans);
		script_row_t r;
		r           = cmd_row(m, xf, yf);
		r.typed     = 1'b1;
		r.typed_ans = ans;
		return r;
	endfunction

	function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		script_row_t r;
		r         = cmd_row(CMD_PLOT);
		r.kind    = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	// mostly near the screen, sometimes the edges and extremes, sometimes anything
	function automatic coord_t pick_coord();
		int roll;
		int v;
		int edges [8];
		edges = '{-32768, 32767, -1, 0, HEIGHT - 1, HEIGHT, WIDTH - 1, WIDTH};
		roll  = $urandom_range(0, 99);
		if (roll < 85) begin
			v = $urandom_range(0, WIDTH + 7);
			v = v - 4;
			return coord_t'(v);
		end
		if (roll < 95) return coord_t'(edges[$urandom_range(0, 7)]);
		return coord_t'($urandom);
	endfunction

	// present one command word, wait for it to be taken, then record what it owes
	task automatic issue_command(logic [MODE_W-1:0] m, coord_t xf, coord_t yf,
			coord_t xl, coord_t yl, bit typed, answer_t typed_ans);
		answer_t predicted;
		// occasional gap of random length so idle cycles land on every stage
		if (!calm && $urandom_range(0, 99) < 9) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		cmd.valid   <= 1'b1;
		cmd.mode    <= m;
		cmd.x_first <= xf;
		cmd.y_first <= yf;
		cmd.x_last  <= xl;
		cmd.y_last  <= yl;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		predicted = predict_answer(m, xf, yf, xl, yl);
		awaited_answers.push_back(typed ? typed_ans : predicted);
		if (m <= CMD_CLEAR) commands_sent++;
	endtask

	// stop sending and let every owed answer come back
	task automatic wait_for_answers();
		cmd.valid <= 1'b0;
		do @(posedge clk); while (awaited_answers.size() != 0);
	endtask

	// leaves cfg_we high; the caller lowers it after the last write of a run
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_ROTATION:    cur_rotation = val;
			REG_DRAW_MODE:   cur_draw     = val;
			REG_FORE_COLOUR: cur_fore     = val[0];
			REG_BACK_COLOUR: cur_back     = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [1:0] rot, logic [1:0] draw, logic [1:0] fore,
			logic [1:0] back);
		write_register(REG_ROTATION, rot);
		write_register(REG_DRAW_MODE, draw);
		write_register(REG_FORE_COLOUR, fore);
		write_register(REG_BACK_COLOUR, back);
		cfg_we <= 1'b0;
	endtask

	// one random command: mostly single pixels, rectangles mostly small
	task automatic issue_random_command();
		int                roll;
		int                x1;
		int                y1;
		logic [MODE_W-1:0] m;
		coord_t            xf;
		coord_t            yf;
		coord_t            xl;
		coord_t            yl;
		roll = $urandom_range(0, 99);
		if (roll < 32) m = CMD_PLOT;
		else if (roll < 64) m = CMD_READ;
		else if (roll < 77) m = CMD_FILL;
		else if (roll < 88) m = CMD_ERASE;
		else if (roll < 91) m = CMD_CLEAR;
		else if (roll < 94) m = CMD_SPARE_FIRST + 3'($urandom_range(0, 2));
		else m = CMD_READ;
		xf = pick_coord();
		yf = pick_coord();
		// ignored corner still carries random bits on single-pixel commands
		xl = coord_t'($urandom);
		yl = coord_t'($urandom);
		if (m == CMD_FILL || m == CMD_ERASE) begin
			roll = $urandom_range(0, 99);
			if (roll < 85) begin
				// small box; a last corner one below the first on an axis makes it empty
				x1 = int'(xf) + $urandom_range(0, 8) - 1;
				y1 = int'(yf) + $urandom_range(0, 8) - 1;
				xl = coord_t'(x1);
				yl = coord_t'(y1);
			end else if (roll < 97) begin
				xl = pick_coord();
				yl = pick_coord();
			end else begin
				xf = coord_t'(-32768);
				yf = coord_t'(-32768);
				xl = coord_t'(32767);
				yl = coord_t'(32767);
			end
		end
		issue_command(m, xf, yf, xl, yl, 1'b0, NO_ANSWER);
	endtask

	// ---------------------------------------------------------------- main sequence

	initial begin
		int          phase;
		logic [1:0]  draw;
		script_row_t r;

		// every input known from the start, reset held low
		arst_n      = 1'b0;
		cmd.valid   = 1'b0;
		cmd.mode    = CMD_PLOT;
		cmd.x_first = '0;
		cmd.y_first = '0;
		cmd.x_last  = '0;
		cmd.y_last  = '0;
		res.ready   = 1'b0;
		cfg_we      = 1'b0;
		cfg_idx     = REG_ROTATION;
		cfg_data    = '0;
		calm        = 1'b0;
		mismatches  = 0;

		// register values and store contents after reset
		wipe_frame();
		cur_rotation = ROT_0;
		cur_draw     = DRAW_NORMAL;
		cur_fore     = 1'b1;
		cur_back     = 1'b0;

		directed_rows = '{
			// store comes out of reset cleared
			known_row(CMD_READ, 0, 0, READ_ZERO),
			cmd_row(CMD_PLOT, 0, 0),
			cmd_row(CMD_READ, 0, 0),
			// far corner of the screen
			cmd_row(CMD_PLOT, WIDTH - 1, HEIGHT - 1),
			cmd_row(CMD_READ, WIDTH - 1, HEIGHT - 1),
			// just off the right and bottom edges, and the coordinate extremes
			known_row(CMD_READ, WIDTH, 0, READ_ZERO),
			known_row(CMD_READ, 0, HEIGHT, READ_ZERO),
			cmd_row(CMD_PLOT, -32768, 32767),
			known_row(CMD_READ, 32767, -32768, READ_ZERO),
			// rectangle covering all of the coordinate space, clipped to the screen
			cmd_row(CMD_FILL, -32768, -32768, 32767, 32767),
			cmd_row(CMD_READ, 40, 20),
			// empty rectangles with corners swapped on one axis, then a real erase
			cmd_row(CMD_ERASE, 10, 0, 5, HEIGHT - 1),
			cmd_row(CMD_ERASE, 0, 9, WIDTH - 1, 3),
			cmd_row(CMD_ERASE, 0, 0, 7, 7),
			cmd_row(CMD_READ, 3, 3),
			// spare commands answer with an empty word
			known_row(CMD_SPARE_FIRST, 1, 1, NO_ANSWER),
			known_row(CMD_SPARE_LAST, 2, 2, NO_ANSWER),
			// xor toggles the pixel back on
			reg_row(REG_DRAW_MODE, DRAW_XOR),
			reg_row(REG_FORE_COLOUR, 2'd1),
			cmd_row(CMD_PLOT, 3, 3),
			cmd_row(CMD_READ, 3, 3),
			// quarter turn: logical origin lands on the top-right column
			reg_row(REG_ROTATION, ROT_90),
			cmd_row(CMD_PLOT, 0, 0),
			cmd_row(CMD_READ, 0, 0),
			// three-quarter turn with the spare draw mode: nothing may change
			reg_row(REG_ROTATION, ROT_270),
			reg_row(REG_DRAW_MODE, DRAW_SPARE),
			reg_row(REG_FORE_COLOUR, 2'd0),
			reg_row(REG_BACK_COLOUR, 2'd1),
			cmd_row(CMD_PLOT, 5, 5),
			cmd_row(CMD_ERASE, 0, 0, HEIGHT - 1, WIDTH - 1),
			cmd_row(CMD_READ, 5, 5),
			// half turn, and-invert clears whatever the colour
			reg_row(REG_ROTATION, ROT_180),
			reg_row(REG_DRAW_MODE, DRAW_ANDINV),
			cmd_row(CMD_FILL, 0, 0, 10, 10),
			cmd_row(CMD_READ, 4, 4),
			// whole-buffer clear
			cmd_row(CMD_CLEAR),
			known_row(CMD_READ, 40, 20, READ_ZERO)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed part; register writes only once the engine has gone quiet
		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.kind == ROW_REG) begin
				if (i == 0 || directed_rows[i - 1].kind == ROW_CMD) wait_for_answers();
				write_register(r.reg_idx, r.reg_val);
				if (i + 1 == directed_rows.size() || directed_rows[i + 1].kind != ROW_REG)
					cfg_we <= 1'b0;
			end else begin
				issue_command(r.mode, coord_t'(r.xf), coord_t'(r.yf), coord_t'(r.xl),
					coord_t'(r.yl), r.typed, r.typed_ans);
			end
		end

		// random phases; each starts with the sender held until all answers are in
		phase = 0;
		while (commands_sent < ITEM_TARGET) begin
			wait_for_answers();
			// one whole phase with no idling on either side
			calm = (phase == 2);
			draw = ($urandom_range(0, 9) == 0) ? DRAW_SPARE : 2'($urandom_range(0, 2));
			apply_settings(2'(phase), draw, 2'($urandom_range(0, 3)),
				2'($urandom_range(0, 3)));
			repeat ($urandom_range(30, 90)) issue_random_command();
			phase++;
		end

		wait_for_answers();
		calm = 1'b0;
		// anything arriving now is an answer nobody asked for
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	// ---------------------------------------------------------------- result side

	// result receiver stalls at random except in the calm phase
	always @(posedge clk) begin
		res.ready <= calm || ($urandom_range(0, 99) >= 9);
	end

	// every taken result word is matched against the oldest owed answer
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && res.valid && res.ready) begin
			if (awaited_answers.size() == 0) begin
				$display("%0t: unexpected result word pixel_value %0b was_read %0b",
					$time, res.pixel_value, res.was_read);
				mismatches++;
			end else begin
				want = awaited_answers.pop_front();
				if (res.pixel_value !== want.pixel_value) begin
					$display("%0t: pixel_value expected %0b got %0b",
						$time, want.pixel_value, res.pixel_value);
					mismatches++;
				end
				if (res.was_read !== want.was_read) begin
					$display("%0t: was_read expected %0b got %0b",
						$time, want.was_read, res.was_read);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d answers outstanding", $time,
				awaited_answers.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

endmodule
